// ===== design/cfr_pkg.sv =====
// Package for the checksummed frame receiver: payload types, protocol bytes,
// frame layout constants and the readout sequencer state type.
// No dependencies; the interfaces and the top level import it.
package cfr_pkg;

	typedef logic [7:0]  rx_byte_t;
	typedef logic [3:0]  field_idx_t;
	typedef logic [31:0] field_val_t;

	localparam rx_byte_t RESTART_BYTE = 8'hA5;
	localparam rx_byte_t END_BYTE     = 8'h5A;

	// A good frame holds exactly this many bytes, the last one being the checksum.
	localparam int FRAME_LEN = 40;

	// Fields below this index are single bytes; the rest are 32-bit words.
	localparam field_idx_t NUM_BYTE_FIELDS = 4'd3;
	localparam field_idx_t LAST_FIELD_IDX  = 4'd11;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_READ    = 4'b0010,
		ST_CAPTURE = 4'b0100,
		ST_PUSH    = 4'b1000
	} seq_state_t;

endpackage

// ===== design/cfr_rx_if.sv =====
// Handshake channel that carries one received byte per transaction.
// Depends on cfr_pkg for the payload type.
interface cfr_rx_if import cfr_pkg::*; ();
	logic     valid;
	logic     ready;
	rx_byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/cfr_field_if.sv =====
// Handshake channel that carries one decoded frame field per transaction.
// Depends on cfr_pkg for the payload types.
interface cfr_field_if import cfr_pkg::*; ();
	logic       valid;
	logic       ready;
	field_idx_t field_index;
	field_val_t field_value;
	logic       last_field;

	modport source (output valid, output field_index, output field_value, output last_field,
		input ready);
	modport sink (input valid, input field_index, input field_value, input last_field,
		output ready);
endinterface

// ===== design/cfr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/checksummed_frame_receiver_top.sv =====
// Checksummed frame receiver, top level.
// Depends on cfr_pkg, cfr_rx_if, cfr_field_if and cfr_ram.
//
// The block takes a serial byte stream, one byte per rx transaction, and
// extracts checksummed frames from it. The byte 0xA5 restarts collection and
// 0x5A ends a frame; every other byte is written into a MAX_FRAME-entry frame
// store at the current byte count. Bytes that arrive with the store full are
// discarded and mark the frame as overflowed. At the end byte the frame is
// accepted only if exactly 40 bytes were collected, none overflowed, and the
// last byte equals the 8-bit wrapping sum of the 39 bytes before it; the sum
// is kept as the bytes arrive, so the decision is made in the cycle the end
// byte is taken. An accepted frame produces twelve field transactions: speed,
// turn and reload request bytes (zero-extended), then nine 32-bit gain words
// assembled little-endian from bytes 3 to 38, the twelfth marked last_field.
// Rejected frames produce nothing, and the count and overflow mark are
// cleared by every end byte. Timing: a data, restart or rejected end byte is
// taken every cycle outside a readout. An accepted end byte starts a readout
// that fetches the 39 field bytes from the store one at a time, each through
// a read state and a capture state around the store's registered read port,
// then hands each of the twelve fields to the output register in a push
// state that waits while the field sink stalls. rx.ready is low for the whole
// readout, which also keeps new writes from overtaking the store reads. The
// output register lets the receiver take new bytes while the final field
// still waits to be taken. The frame store has no reset; entries are always
// written before a good frame reads them.
module checksummed_frame_receiver_top import cfr_pkg::*; #(
	parameter int MAX_FRAME = 64
) (
	input logic         clk,
	input logic         arst_n,
	cfr_rx_if.sink      rx,
	cfr_field_if.source fld
);

	localparam int AW = $clog2(MAX_FRAME);
	localparam int CW = $clog2(MAX_FRAME + 1);
	localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_FRAME);
	localparam logic [CW-1:0] FRAME_CNT = CW'(FRAME_LEN);

	// Collection state.
	logic [CW-1:0] count_q;
	logic          ovf_q;
	rx_byte_t      sum_prev_q;  // sum of all stored bytes except the newest
	rx_byte_t      last_byte_q; // newest stored byte

	// Readout sequencer.
	seq_state_t    state_q;
	logic [AW-1:0] rd_ptr_q;
	field_idx_t    field_q;
	logic [1:0]    byte_sel_q;
	field_val_t    word_q;

	// Output register.
	logic          out_valid_q;
	field_idx_t    out_index_q;
	field_val_t    out_value_q;
	logic          out_last_q;

	logic          rx_acc;
	logic          is_restart;
	logic          is_end;
	logic          has_room;
	logic          wr_en;
	logic          rd_en;
	rx_byte_t      rd_data;
	logic          frame_ok;
	logic          byte_field;
	logic          field_done;
	logic          out_load;

	assign rx.ready   = (state_q == ST_IDLE);
	assign rx_acc     = rx.valid && rx.ready;
	assign is_restart = (rx.rx_byte == RESTART_BYTE);
	assign is_end     = (rx.rx_byte == END_BYTE);
	assign has_room   = (count_q < MAX_CNT);
	assign wr_en      = rx_acc && !is_restart && !is_end && has_room;
	assign rd_en      = (state_q == ST_READ);

	// The checksum byte is the newest one, and the running sum covers all before it.
	assign frame_ok   = (count_q == FRAME_CNT) && !ovf_q && (last_byte_q == sum_prev_q);

	assign byte_field = (field_q < NUM_BYTE_FIELDS);
	assign field_done = byte_field || (byte_sel_q == 2'd3);
	assign out_load   = (state_q == ST_PUSH) && (!out_valid_q || fld.ready);

	cfr_ram #(
		.WIDTH (8),
		.DEPTH (MAX_FRAME)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (rx.rx_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	// Byte collection, overflow tracking and the running checksum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			sum_prev_q  <= '0;
			last_byte_q <= '0;
		end else if (rx_acc) begin
			if (is_restart || is_end) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (has_room) begin
				count_q     <= count_q + 1'b1;
				sum_prev_q  <= (count_q == '0) ? '0 : rx_byte_t'(sum_prev_q + last_byte_q);
				last_byte_q <= rx.rx_byte;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Readout sequencer: read a byte, capture it, and push each finished field.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_ptr_q   <= '0;
			field_q    <= '0;
			byte_sel_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rx_acc && is_end && frame_ok) begin
						rd_ptr_q   <= '0;
						field_q    <= '0;
						byte_sel_q <= '0;
						state_q    <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CAPTURE;
				end
				ST_CAPTURE: begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
					if (field_done) begin
						byte_sel_q <= '0;
						state_q    <= ST_PUSH;
					end else begin
						byte_sel_q <= byte_sel_q + 1'b1;
						state_q    <= ST_READ;
					end
				end
				ST_PUSH: begin
					if (out_load) begin
						if (field_q == LAST_FIELD_IDX) begin
							state_q <= ST_IDLE;
						end else begin
							field_q <= field_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Field assembly; gain words fill from the top so the first byte ends lowest.
	always_ff @(posedge clk) begin
		if (state_q == ST_CAPTURE) begin
			if (byte_field) begin
				word_q <= {24'd0, rd_data};
			end else begin
				word_q <= {rd_data, word_q[31:8]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (fld.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_index_q <= field_q;
			out_value_q <= word_q;
			out_last_q  <= (field_q == LAST_FIELD_IDX);
		end
	end

	assign fld.valid       = out_valid_q;
	assign fld.field_index = out_index_q;
	assign fld.field_value = out_value_q;
	assign fld.last_field  = out_last_q;

endmodule
